// ===== hdl/evad_pkg.sv =====
`timescale 1ns / 1ps

package evad_pkg;

  localparam int ENERGY_W = 29;
  localparam int SILENCE_W = 8;
  localparam int BYTES_W = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENERGY_THRESHOLD   = 2'd0,
    CFG_END_SILENCE_FRAMES = 2'd1,
    CFG_MIN_SPEECH_BYTES   = 2'd2,
    CFG_UNUSED             = 2'd3
  } cfg_index_t;

  localparam logic [ENERGY_W-1:0]  RESET_ENERGY_THRESHOLD   = 29'd23000000;
  localparam logic [SILENCE_W-1:0] RESET_END_SILENCE_FRAMES = 8'd5;
  localparam logic [BYTES_W-1:0]   RESET_MIN_SPEECH_BYTES   = 32'd31000;

  typedef struct packed {
    logic signed [7:0] sample_byte;
    logic              frame_last;
  } in_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] frame_energy;
    logic                speech_frame;
    logic                utterance_end;
    logic                utterance_long_enough;
    logic [BYTES_W-1:0]  speech_byte_total;
  } out_t;

endpackage

// ===== hdl/energy_voice_activity_detector.sv =====
`timescale 1ns / 1ps

// Energy voice activity detector. Signed audio bytes enter one per cycle on the
// in channel while the skid register is empty; each beat is first captured in
// an input register, and from there a single pass of logic squares the byte,
// adds it to the frame energy and, on the last byte of a frame (or its
// FRAME_BYTES-th byte), decides speech or silence, updates the utterance state
// and loads the result register. The sustained rate is one byte per cycle, set
// by that per-byte accumulate and state update, while the skid register is
// empty. A two-entry output (result register plus skid register) lets bytes keep
// flowing while a result waits. Configuration writes take effect at once and
// are expected only while the block is idle; cfg_ready is always high.
module energy_voice_activity_detector
  import evad_pkg::*;
#(
  parameter int FRAME_BYTES = 16384
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(FRAME_BYTES);

  // configuration
  logic [ENERGY_W-1:0]  energy_threshold;
  logic [SILENCE_W-1:0] end_silence_frames;
  logic [BYTES_W-1:0]   min_speech_bytes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_threshold   <= RESET_ENERGY_THRESHOLD;
      end_silence_frames <= RESET_END_SILENCE_FRAMES;
      min_speech_bytes   <= RESET_MIN_SPEECH_BYTES;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ENERGY_THRESHOLD:   energy_threshold   <= cfg_data[ENERGY_W-1:0];
        CFG_END_SILENCE_FRAMES: end_silence_frames <= cfg_data[SILENCE_W-1:0];
        CFG_MIN_SPEECH_BYTES:   min_speech_bytes   <= cfg_data[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic s1_valid;
  in_t  s1_data;
  logic s1_fire;
  logic skid_valid;

  assign s1_fire  = s1_valid && !skid_valid;
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  // frame and utterance state
  logic [ENERGY_W-1:0]  energy_sum;
  logic [CNT_W-1:0]     frame_byte_count;
  logic                 speech_active;
  logic [SILENCE_W-1:0] silence_phase;
  logic [BYTES_W-1:0]   speech_bytes;

  logic [7:0]           mag;
  logic [15:0]          square;
  logic [ENERGY_W-1:0]  energy;
  logic [CNT_W-1:0]     len;
  logic                 frame_end;
  logic                 is_speech;
  logic [BYTES_W:0]     bytes_sum;
  logic [BYTES_W-1:0]   bytes_sat;
  logic [SILENCE_W:0]   modulus;
  logic [SILENCE_W:0]   phase_inc;
  logic                 phase_wrap;
  logic [SILENCE_W-1:0] phase_new;
  logic                 ended;
  logic                 long_enough;
  out_t                 result;

  always_comb begin
    mag       = s1_data.sample_byte[7] ? 8'(-s1_data.sample_byte) : s1_data.sample_byte;
    square    = 16'(mag) * 16'(mag);
    energy    = energy_sum + ENERGY_W'(square);
    len       = frame_byte_count + CNT_W'(1);
    frame_end = s1_data.frame_last || (len >= LEN_LIMIT);
    is_speech = energy > energy_threshold;

    bytes_sum = {1'b0, speech_bytes} + (BYTES_W + 1)'(len);
    bytes_sat = bytes_sum[BYTES_W] ? {BYTES_W{1'b1}} : bytes_sum[BYTES_W-1:0];

    // a modulus of zero means a full 256-frame cycle
    modulus    = (end_silence_frames == '0) ? (SILENCE_W + 1)'(1 << SILENCE_W)
                                            : {1'b0, end_silence_frames};
    phase_inc  = {1'b0, silence_phase} + (SILENCE_W + 1)'(1);
    phase_wrap = phase_inc >= modulus;
    phase_new  = phase_wrap ? '0 : phase_inc[SILENCE_W-1:0];

    ended       = !is_speech && phase_wrap && speech_active;
    long_enough = ended && (speech_bytes >= min_speech_bytes);

    result.frame_energy          = energy;
    result.speech_frame          = is_speech;
    result.utterance_end         = ended;
    result.utterance_long_enough = long_enough;
    result.speech_byte_total     = is_speech ? bytes_sat : speech_bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum       <= '0;
      frame_byte_count <= '0;
      speech_active    <= 1'b0;
      silence_phase    <= '0;
      speech_bytes     <= '0;
    end else if (s1_fire) begin
      if (!frame_end) begin
        energy_sum       <= energy;
        frame_byte_count <= len;
      end else begin
        energy_sum       <= '0;
        frame_byte_count <= '0;
        if (is_speech) begin
          speech_active <= 1'b1;
          speech_bytes  <= bytes_sat;
        end else if (ended) begin
          speech_active <= 1'b0;
          speech_bytes  <= '0;
          silence_phase <= '0;
        end else begin
          silence_phase <= phase_new;
        end
      end
    end
  end

  // result register with skid stage
  logic produce;
  logic out_take;
  out_t skid_data;

  assign produce  = s1_fire && frame_end;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (produce) begin
        if (!out_valid || out_take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (produce) begin
      if (!out_valid || out_take) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

endmodule

// ===== sim/energy_voice_activity_detector_test.sv =====
`timescale 1ns / 1ps

module energy_voice_activity_detector_test;
  import evad_pkg::*;

  localparam int FRAME_BYTES = 16384;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 75;
  localparam int PHASES = 6;
  localparam int REPORT_MAX = 10;

  // one directed row: count bytes of one value, frame_last (if last is set) on the final byte only
  typedef struct packed {
    logic signed [7:0] value;
    logic [14:0]       count;
    logic              last;
    logic              typed;
    out_t              result;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [22] = '{
    '{8'sd0,    15'd1,     1'b1, 1'b1, '{29'd0,         1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'sd127,  15'd1,     1'b1, 1'b1, '{29'd16129,     1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'sh80,   15'd1,     1'b1, 1'b1, '{29'd16384,     1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'shFF,   15'd1,     1'b1, 1'b1, '{29'd1,         1'b0, 1'b0, 1'b0, 32'd0}},
    // silence counter wraps with no utterance open
    '{8'sd1,    15'd1,     1'b1, 1'b1, '{29'd1,         1'b0, 1'b0, 1'b0, 32'd0}},
    // overlong frame closes itself at full energy
    '{8'sh80,   15'd16384, 1'b0, 1'b1, '{29'd268435456, 1'b1, 1'b0, 1'b0, 32'd16384}},
    '{8'sd100,  15'd2400,  1'b1, 1'b1, '{29'd24000000,  1'b1, 1'b0, 1'b0, 32'd18784}},
    '{-8'sd100, 15'd1000,  1'b0, 1'b0, '0},
    '{8'sd50,   15'd1000,  1'b1, 1'b1, '{29'd12500000,  1'b0, 1'b0, 1'b0, 32'd18784}},
    '{8'sd0,    15'd1,     1'b1, 1'b1, '{29'd0,         1'b0, 1'b0, 1'b0, 32'd18784}},
    '{8'sd0,    15'd1,     1'b1, 1'b1, '{29'd0,         1'b0, 1'b0, 1'b0, 32'd18784}},
    '{8'sd0,    15'd1,     1'b1, 1'b1, '{29'd0,         1'b0, 1'b0, 1'b0, 32'd18784}},
    '{8'sd0,    15'd1,     1'b1, 1'b1, '{29'd0,         1'b0, 1'b1, 1'b0, 32'd18784}},
    '{8'sd127,  15'd16384, 1'b0, 1'b1, '{29'd264257536, 1'b1, 1'b0, 1'b0, 32'd16384}},
    '{-8'sd127, 15'd16384, 1'b0, 1'b1, '{29'd264257536, 1'b1, 1'b0, 1'b0, 32'd32768}},
    '{8'sd0,    15'd1,     1'b1, 1'b1, '{29'd0,         1'b0, 1'b0, 1'b0, 32'd32768}},
    '{8'sd0,    15'd1,     1'b1, 1'b1, '{29'd0,         1'b0, 1'b0, 1'b0, 32'd32768}},
    '{8'sd0,    15'd1,     1'b1, 1'b1, '{29'd0,         1'b0, 1'b0, 1'b0, 32'd32768}},
    '{8'sd0,    15'd1,     1'b1, 1'b1, '{29'd0,         1'b0, 1'b0, 1'b0, 32'd32768}},
    '{8'sd0,    15'd1,     1'b1, 1'b1, '{29'd0,         1'b0, 1'b1, 1'b1, 32'd32768}},
    // energy equal to the threshold is still silence
    '{8'sd100,  15'd2300,  1'b1, 1'b1, '{29'd23000000,  1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'sd100,  15'd2301,  1'b1, 1'b1, '{29'd23010000,  1'b1, 1'b0, 1'b0, 32'd2301}}
  };

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // detector mirror: settings and running state
  logic [ENERGY_W-1:0]  thr_cfg = RESET_ENERGY_THRESHOLD;
  logic [SILENCE_W-1:0] hang_cfg = RESET_END_SILENCE_FRAMES;
  logic [BYTES_W-1:0]   min_cfg = RESET_MIN_SPEECH_BYTES;
  logic [ENERGY_W-1:0]  acc_energy = '0;
  logic [14:0]          acc_len = '0;
  logic                 talking = 1'b0;
  logic [SILENCE_W-1:0] quiet_run = '0;
  logic [BYTES_W-1:0]   talk_bytes = '0;

  out_t frames_due[$];

  logic no_idle = 1'b0;
  int   bytes_fed = 0;
  int   frames_seen = 0;
  int   speech_seen = 0;
  int   ends_seen = 0;
  int   long_seen = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  energy_voice_activity_detector #(
    .FRAME_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 16);
  end

  // sends one byte and folds it into the mirror; entered and left at a falling edge
  task automatic feed_byte(input in_t beat, input logic typed, input out_t typed_res);
    logic [7:0]          raw;
    logic [7:0]          mag;
    logic [ENERGY_W-1:0] energy;
    logic [15:0]         len;
    logic [8:0]          modulus;
    logic [8:0]          nxt;
    out_t                res;
    while (!no_idle && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    bytes_fed++;
    raw = beat.sample_byte;
    mag = raw[7] ? 8'd0 - raw : raw;
    energy = acc_energy + 29'(mag) * 29'(mag);
    len = {1'b0, acc_len} + 16'd1;
    if (!beat.frame_last && len < 16'(FRAME_BYTES)) begin
      acc_energy = energy;
      acc_len = len[14:0];
    end else begin
      acc_energy = '0;
      acc_len = '0;
      res = '0;
      res.frame_energy = energy;
      res.speech_frame = energy > thr_cfg;
      if (res.speech_frame) begin
        talking = 1'b1;
        if (talk_bytes > 32'hFFFF_FFFF - 32'(len)) begin
          talk_bytes = '1;
        end else begin
          talk_bytes = talk_bytes + 32'(len);
        end
        res.speech_byte_total = talk_bytes;
      end else begin
        res.speech_byte_total = talk_bytes;
        modulus = (hang_cfg == '0) ? 9'd256 : {1'b0, hang_cfg};
        nxt = {1'b0, quiet_run} + 9'd1;
        if (nxt >= modulus) begin
          nxt = '0;
        end
        quiet_run = nxt[7:0];
        if (quiet_run == '0 && talking) begin
          res.utterance_end = 1'b1;
          res.utterance_long_enough = talk_bytes >= min_cfg;
          talking = 1'b0;
          talk_bytes = '0;
        end
      end
      frames_due.push_back(typed ? typed_res : res);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENERGY_THRESHOLD: begin
        thr_cfg = val[ENERGY_W-1:0];
      end
      CFG_END_SILENCE_FRAMES: begin
        hang_cfg = val[SILENCE_W-1:0];
      end
      CFG_MIN_SPEECH_BYTES: begin
        min_cfg = val;
      end
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  // hold the sender until every frame result is back and the pipe has emptied
  task automatic drain();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected frame result: energy=%0d speech=%0b end=%0b long=%0b total=%0d",
                   out_data.frame_energy, out_data.speech_frame, out_data.utterance_end,
                   out_data.utterance_long_enough, out_data.speech_byte_total);
        end
      end else begin
        want = frames_due.pop_front();
        frames_seen++;
        speech_seen += int'(want.speech_frame);
        ends_seen += int'(want.utterance_end);
        long_seen += int'(want.utterance_long_enough);
        if (out_data.frame_energy !== want.frame_energy ||
            out_data.speech_frame !== want.speech_frame ||
            out_data.utterance_end !== want.utterance_end ||
            out_data.utterance_long_enough !== want.utterance_long_enough ||
            out_data.speech_byte_total !== want.speech_byte_total) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("frame %0d mismatch: expected energy=%0d speech=%0b end=%0b long=%0b total=%0d",
                     frames_seen, want.frame_energy, want.speech_frame, want.utterance_end,
                     want.utterance_long_enough, want.speech_byte_total);
            $display("  got energy=%0d speech=%0b end=%0b long=%0b total=%0d",
                     out_data.frame_energy, out_data.speech_frame, out_data.utterance_end,
                     out_data.utterance_long_enough, out_data.speech_byte_total);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, frames_due.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t row;
    in_t      beat;
    logic [CFG_DATA_W-1:0] thr_set;
    logic [CFG_DATA_W-1:0] hang_set;
    logic [CFG_DATA_W-1:0] min_set;
    int       frame_len;
    int       sent;
    logic     loud;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part on reset settings
    for (int r = 0; r < 22; r++) begin
      row = DIR_ROWS[r];
      no_idle = (r == 13 || r == 14);
      for (int k = 0; k < int'(row.count); k++) begin
        beat.sample_byte = row.value;
        beat.frame_last = (k == int'(row.count) - 1) ? row.last : 1'b0;
        feed_byte(beat, row.typed, row.result);
      end
    end
    no_idle = 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          thr_set = 32'd20000;
          hang_set = 32'd3;
          min_set = 32'd40;
        end
        1: begin
          thr_set = 32'd0;
          hang_set = 32'd1;
          min_set = 32'd0;
        end
        2: begin
          // wide values keep only the register width
          thr_set = 32'hFFFF_FFFF;
          hang_set = 32'd255;
          min_set = 32'hFFFF_FFFF;
        end
        3: begin
          // modulus drops below the silence count left by the last phase
          thr_set = 32'd50000;
          hang_set = 32'h0000_0104;
          min_set = 32'd20;
        end
        4: begin
          // zero modulus counts as 256
          thr_set = $urandom_range(0, 120000);
          hang_set = 32'd0;
          min_set = $urandom_range(0, 100);
        end
        default: begin
          thr_set = $urandom_range(0, 120000);
          hang_set = $urandom_range(1, 8);
          min_set = $urandom_range(0, 150);
        end
      endcase
      write_reg(CFG_ENERGY_THRESHOLD, thr_set);
      write_reg(CFG_END_SILENCE_FRAMES, hang_set);
      write_reg(CFG_MIN_SPEECH_BYTES, min_set);
      if (ph == 4) begin
        write_reg(CFG_UNUSED, $urandom);
      end
      cfg_valid <= 1'b0;
      no_idle = (ph == 1);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        frame_len = ($urandom_range(0, 39) == 0) ? $urandom_range(13, 300)
                                                 : $urandom_range(1, 12);
        loud = $urandom_range(0, 1) == 1;
        for (int k = 0; k < frame_len; k++) begin
          beat.sample_byte = loud ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 16) - 8);
          beat.frame_last = (k == frame_len - 1);
          feed_byte(beat, 1'b0, '0);
          sent++;
        end
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("fed %0d bytes, checked %0d frames: %0d speech, %0d utterance ends, %0d long enough",
             bytes_fed, frames_seen, speech_seen, ends_seen, long_seen);
    $display("reset settings plus %0d register phases incl. extreme, wide and zero values",
             PHASES);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
